/* rtl/djb_pkg.sv */
// Package for the digit-jump shortest path core.
// Holds sizes and widths; no dependencies.
package djb_pkg;
  localparam int unsigned MaxLen = 4096;
  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned NumClasses = 10;
  localparam int unsigned DigitW = 4;
  localparam int unsigned DistW = 12;
  localparam logic [DigitW-1:0] MaxDigit = 4'd9;
endpackage

/* rtl/digit_jump_bfs_distance_core.sv */
// Top level of the digit-jump shortest path core: digit loading, class
// position lists and a sequenced breadth-first search. Uses djb_pkg.
//
// channel | signals                      | direction
// in      | in_valid/in_ready, digit,last | into the core
// out     | out_valid/out_ready, distance | out of the core
//
// Digits are stored while the core is in its load state. After the last digit
// the core clears its visit marks (one entry per cycle) and then seeds the
// search. Each dequeued position is read from the queue, its digit and distance
// are read, each neighbor that exists is visited and the queue head advances.
// Expanding a digit class visits each member in turn from its position list.
// The result appears once position 0 is reached and the current position is
// finished. Reset is asynchronous and clears all control state. While a result
// waits at the output the core accepts nothing.
module digit_jump_bfs_distance_core
  import djb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DigitW-1:0] digit_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DistW-1:0]  distance_o
);
  localparam logic [3:0] SLoad = 4'd0, SClr = 4'd1, SStart = 4'd2, SDeq = 4'd3,
    SDeqR = 4'd4, SCls = 4'd5, SClsR = 4'd6, SLeft = 4'd7, SRight = 4'd8,
    SVis = 4'd9, SCheck = 4'd10, SOut = 4'd11, SClsRd = 4'd12, SClsPos = 4'd13,
    SClsNext = 4'd14, SAdv = 4'd15;

  logic [3:0] state_q, ret_q;
  logic [CntW-1:0] len_q;
  logic [CntW-1:0] cnt_q [NumClasses];
  logic [NumClasses-1:0] exp_q;
  logic [AddrW-1:0] clr_q, head_q, s_q, vpos_q, cidx_q;
  logic [CntW-1:0] tail_q;
  logic [DistW:0] d_q;
  logic [DistW-1:0] res_q;
  logic [3:0] cls_q;
  logic found_q;

  // Memories, each with one registered read.
  logic [DigitW-1:0] dig_mem [MaxLen];
  logic [DistW:0]    dist_mem [MaxLen];
  logic [AddrW-1:0]  q_mem [MaxLen];
  logic [AddrW-1:0]  cp_mem [NumClasses*MaxLen];
  logic [DigitW-1:0] dig_rd;
  logic [DistW:0]    dist_rd;
  logic [AddrW-1:0]  q_rd, cp_rd;

  logic [DigitW-1:0] dg;
  logic in_fire, load_ok, clr_we, vis_we;
  logic [AddrW-1:0] len_a;

  assign dg = (digit_i > MaxDigit) ? MaxDigit : digit_i;
  assign in_ready_o = (state_q == SLoad);
  assign in_fire = in_valid_i && in_ready_o;
  assign load_ok = (len_q < CntW'(MaxLen));
  assign len_a = len_q[AddrW-1:0];
  assign out_valid_o = (state_q == SOut);
  assign distance_o = res_q;
  assign clr_we = (state_q == SClr);
  // Visit write happens in SCheck when the entry is still unvisited.
  assign vis_we = (state_q == SCheck) && (dist_rd[DistW] == 1'b1);

  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok) begin
      dig_mem[len_a] <= dg;
    end
    dig_rd <= dig_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      dist_mem[clr_q] <= {1'b1, {DistW{1'b0}}};
    end else if (vis_we) begin
      dist_mem[vpos_q] <= d_q;
    end
    dist_rd <= dist_mem[(state_q == SVis) ? vpos_q : s_q];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      q_mem[tail_q[AddrW-1:0]] <= vpos_q;
    end
    q_rd <= q_mem[head_q];
  end

  // Each digit class owns a MaxLen-entry slice, addressed by {class, index}.
  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok) begin
      cp_mem[{dg, cnt_q[dg][AddrW-1:0]}] <= len_a;
    end
    cp_rd <= cp_mem[{cls_q, cidx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      ret_q <= SLoad;
      len_q <= '0;
      exp_q <= '0;
      clr_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      found_q <= 1'b0;
      s_q <= '0;
      vpos_q <= '0;
      cidx_q <= '0;
      cls_q <= '0;
      d_q <= '0;
      res_q <= '0;
      for (int i = 0; i < NumClasses; i++) cnt_q[i] <= '0;
    end else begin
      unique case (state_q)
        SLoad: begin
          if (in_fire) begin
            if (load_ok) begin
              len_q <= len_q + 1'b1;
              cnt_q[dg] <= cnt_q[dg] + 1'b1;
            end
            if (last_i) begin
              clr_q <= '0;
              state_q <= SClr;
            end
          end
        end
        SClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(MaxLen - 1)) state_q <= SStart;
        end
        SStart: begin
          head_q <= '0;
          tail_q <= '0;
          found_q <= 1'b0;
          exp_q <= '0;
          vpos_q <= AddrW'(len_q - 1'b1);
          d_q <= '0;
          ret_q <= SDeq;
          state_q <= SVis;
        end
        SDeq: begin
          // Stop when position 0 has been reached or the queue is empty.
          if (found_q || CntW'(head_q) == tail_q) begin
            res_q <= found_q ? res_q : '0;
            state_q <= SOut;
          end else begin
            state_q <= SDeqR;
          end
        end
        SDeqR: begin
          s_q <= q_rd;
          state_q <= SCls;
        end
        SCls: begin
          // The digit and distance reads of the dequeued entry are issued here.
          state_q <= SClsR;
        end
        SClsR: begin
          d_q <= dist_rd + 1'b1;
          cls_q <= dig_rd;
          cidx_q <= '0;
          if (!exp_q[dig_rd] && cnt_q[dig_rd] != '0) begin
            exp_q[dig_rd] <= 1'b1;
            state_q <= SClsRd;
          end else begin
            state_q <= SLeft;
          end
        end
        SClsRd: begin
          // Wait for the registered class list read.
          state_q <= SClsPos;
        end
        SClsPos: begin
          vpos_q <= cp_rd;
          ret_q <= (CntW'(cidx_q) + 1'b1 == cnt_q[cls_q]) ? SLeft : SClsNext;
          state_q <= SVis;
        end
        SClsNext: begin
          cidx_q <= cidx_q + 1'b1;
          state_q <= SClsRd;
        end
        SLeft: begin
          if (s_q != '0) begin
            vpos_q <= s_q - 1'b1;
            ret_q <= SRight;
            state_q <= SVis;
          end else begin
            state_q <= SRight;
          end
        end
        SRight: begin
          if (CntW'(s_q) + 1'b1 < len_q) begin
            vpos_q <= s_q + 1'b1;
            ret_q <= SAdv;
            state_q <= SVis;
          end else begin
            state_q <= SAdv;
          end
        end
        SAdv: begin
          head_q <= head_q + 1'b1;
          state_q <= SDeq;
        end
        SVis: begin
          state_q <= SCheck;
        end
        SCheck: begin
          if (vis_we) begin
            tail_q <= tail_q + 1'b1;
            if (vpos_q == '0) begin
              found_q <= 1'b1;
              res_q <= d_q[DistW-1:0];
            end
          end
          state_q <= ret_q;
        end
        SOut: begin
          if (out_ready_i) begin
            len_q <= '0;
            exp_q <= '0;
            for (int i = 0; i < NumClasses; i++) cnt_q[i] <= '0;
            state_q <= SLoad;
          end
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CntW'(MaxLen))
    else $error("queue overflow");
endmodule
